[rtl/core/sst_pkg.sv]
// Shared types and constants for the sorted set table.
// Request and status codes, cell commands, controller states.
// No dependencies.
package sst_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int KEY_W        = 32;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_SEARCH = 2'd2,
        REQ_LIST   = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        STS_INSERTED  = 3'd0,
        STS_DUPLICATE = 3'd1,
        STS_REMOVED   = 3'd2,
        STS_ABSENT    = 3'd3,
        STS_FULL      = 3'd4,
        STS_SEARCH    = 3'd5,
        STS_ELEMENT   = 3'd6,
        STS_EMPTY     = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_ROTATE = 2'd3
    } cell_op_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_LIST = 3'b100
    } state_t;

    typedef struct packed {
        cell_op_t                op;
        logic signed [KEY_W-1:0] key;
    } sst_cmd_t;

endpackage

[rtl/core/sst_cell.sv]
// One slot of the sorted set chain: holds a value and compares it to the key.
// Shifts with its neighbors on insert, remove and list rotation.
// Depends on sst_pkg.
module sst_cell import sst_pkg::*; (
    input  logic                    aclk,
    input  sst_cmd_t                cmd,
    input  logic signed [KEY_W-1:0] head_value,
    input  logic signed [KEY_W-1:0] left_value,
    input  logic signed [KEY_W-1:0] right_value,
    input  logic                    left_lt,
    input  logic                    occ,
    input  logic                    right_occ,
    output logic signed [KEY_W-1:0] value,
    output logic                    lt,
    output logic                    eq
);

    logic signed [KEY_W-1:0] value_reg;
    logic signed [KEY_W-1:0] value_next;

    assign value = value_reg;
    assign lt    = occ && (value_reg < cmd.key);
    assign eq    = occ && (value_reg == cmd.key);

    always_comb begin
        value_next = value_reg;
        case (cmd.op)
            OP_INSERT: begin
                if (!left_lt) begin
                    value_next = left_value;
                end else if (!lt) begin
                    value_next = cmd.key;
                end
            end
            OP_REMOVE: begin
                if (!lt) begin
                    value_next = right_value;
                end
            end
            OP_ROTATE: begin
                if (occ && !right_occ) begin
                    value_next = head_value;
                end else begin
                    value_next = right_value;
                end
            end
            default: value_next = value_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

endmodule

[rtl/core/sst_chain.sv]
// Row of sst_cell slots wired to their neighbors.
// Derives slot occupancy from the count and reduces the match flags.
// Depends on sst_pkg and sst_cell.
module sst_chain import sst_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                    aclk,
    input  sst_cmd_t                cmd,
    input  logic [CNT_W-1:0]        count,
    output logic                    found,
    output logic signed [KEY_W-1:0] head_value
);

    logic signed [KEY_W-1:0] value_w [CAPACITY];
    logic [CAPACITY-1:0]     lt_w;
    logic [CAPACITY-1:0]     eq_w;
    logic [CAPACITY-1:0]     occ_w;

    assign found      = |eq_w;
    assign head_value = value_w[0];

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [KEY_W-1:0] left_v;
        logic signed [KEY_W-1:0] right_v;
        logic                    left_l;
        logic                    right_o;

        assign occ_w[i] = CNT_W'(i) < count;

        if (i == 0) begin : g_first
            assign left_v = cmd.key;
            assign left_l = 1'b1;
        end else begin : g_mid_l
            assign left_v = value_w[i-1];
            assign left_l = lt_w[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_v = value_w[i];
            assign right_o = 1'b0;
        end else begin : g_mid_r
            assign right_v = value_w[i+1];
            assign right_o = occ_w[i+1];
        end

        sst_cell u_cell (
            .aclk        (aclk),
            .cmd         (cmd),
            .head_value  (value_w[0]),
            .left_value  (left_v),
            .right_value (right_v),
            .left_lt     (left_l),
            .occ         (occ_w[i]),
            .right_occ   (right_o),
            .value       (value_w[i]),
            .lt          (lt_w[i]),
            .eq          (eq_w[i])
        );
    end

endmodule

[rtl/core/sorted_set_table.sv]
// Sorted set table: bounded set of distinct signed values in ascending order.
// Insert, remove, search: the word is registered, then the execute state registers the result once
// the output is free, from a parallel compare and shift across the cell chain; no new word until idle.
// List: after execute, one element per cycle while the output is free, from a one-slot rotation of the chain.
// Reset clears the entry count and control; slot contents are not cleared.
// Depends on sst_pkg and sst_chain.
module sorted_set_table import sst_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] key_value
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [0] found, [32:1] element_value, [39:33] zero
    output logic [2:0]  m_tuser,   // [2:0] status
    output logic        m_tlast    // last_result
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    state_t                  state_reg, state_next;
    req_t                    req_reg, req_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        list_idx_reg, list_idx_next;

    logic                    m_valid_reg, m_valid_next;
    status_t                 m_status_reg, m_status_next;
    logic                    m_found_reg, m_found_next;
    logic signed [KEY_W-1:0] m_elem_reg, m_elem_next;
    logic                    m_last_reg, m_last_next;

    sst_cmd_t                cmd;
    logic                    found;
    logic signed [KEY_W-1:0] head_value;
    logic                    out_free;
    logic                    s_fire;
    logic                    full;
    logic                    list_end;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign list_end = ((list_idx_reg + CNT_W'(1)) == count_reg);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_elem_reg, m_found_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

    sst_chain #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_chain (
        .aclk       (aclk),
        .cmd        (cmd),
        .count      (count_reg),
        .found      (found),
        .head_value (head_value)
    );

    always_comb begin
        state_next    = state_reg;
        req_next      = req_reg;
        key_next      = key_reg;
        count_next    = count_reg;
        list_idx_next = list_idx_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_found_next  = m_found_reg;
        m_elem_next   = m_elem_reg;
        m_last_next   = m_last_reg;
        cmd.op        = OP_HOLD;
        cmd.key       = key_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    req_next   = req_t'(s_tuser);
                    key_next   = s_tdata;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                    m_found_next = 1'b0;
                    m_elem_next  = '0;
                    m_last_next  = 1'b1;
                    unique case (req_reg)
                        REQ_INSERT: begin
                            if (found) begin
                                m_status_next = STS_DUPLICATE;
                            end else if (full) begin
                                m_status_next = STS_FULL;
                            end else begin
                                m_status_next = STS_INSERTED;
                                cmd.op        = OP_INSERT;
                                count_next    = count_reg + CNT_W'(1);
                            end
                        end
                        REQ_REMOVE: begin
                            if (found) begin
                                m_status_next = STS_REMOVED;
                                cmd.op        = OP_REMOVE;
                                count_next    = count_reg - CNT_W'(1);
                            end else begin
                                m_status_next = STS_ABSENT;
                            end
                        end
                        REQ_SEARCH: begin
                            m_status_next = STS_SEARCH;
                            m_found_next  = found;
                        end
                        REQ_LIST: begin
                            if (count_reg == '0) begin
                                m_status_next = STS_EMPTY;
                            end else begin
                                m_valid_next  = m_valid_reg && !m_tready;
                                list_idx_next = '0;
                                state_next    = ST_LIST;
                            end
                        end
                        default: m_status_next = STS_EMPTY;
                    endcase
                end
            end
            ST_LIST: begin
                if (out_free) begin
                    cmd.op        = OP_ROTATE;
                    m_valid_next  = 1'b1;
                    m_status_next = STS_ELEMENT;
                    m_found_next  = 1'b0;
                    m_elem_next   = head_value;
                    m_last_next   = list_end;
                    list_idx_next = list_idx_reg + CNT_W'(1);
                    if (list_end) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            list_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            list_idx_reg <= list_idx_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        key_reg      <= key_next;
        m_status_reg <= m_status_next;
        m_found_reg  <= m_found_next;
        m_elem_reg   <= m_elem_next;
        m_last_reg   <= m_last_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_count_only_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_EXEC) |=> $stable(count_reg))
        else $error("entry count changed outside execute");

    a_fire_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> (state_reg == ST_EXEC))
        else $error("accepted word not executed");

    a_list_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LIST) && out_free && list_end
        |=> (state_reg == ST_IDLE) && m_tvalid && m_tlast
            && (m_tuser == STS_ELEMENT))
        else $error("list did not close with a last element");

endmodule

[sim/sorted_set_monitor.sv]
`timescale 1ns / 100ps
// Channel monitor for the sorted set table: mirrors the set from accepted requests,
// queues the replies each request should give and compares every reply word.
// Depends on sst_pkg for request and status codes.
module sorted_set_monitor import sst_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] key_value
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // [0] found, [32:1] element_value, [39:33] zero
    input  logic [2:0]  m_tuser,   // [2:0] status
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending_replies
);

    typedef struct packed {
        status_t     status;
        logic        found;
        logic [31:0] elem;
        logic        last;
    } set_reply_t;

    logic signed [31:0] members[$];
    set_reply_t         replies_due[$];
    int                 faults = 0;

    function automatic int lower_slot(logic signed [31:0] key);
        int i;
        i = 0;
        while (i < members.size() && members[i] < key)
            i++;
        return i;
    endfunction

    function automatic void queue_reply(status_t st, logic fnd, logic [31:0] elem,
                                        logic last);
        set_reply_t r;
        r.status = st;
        r.found  = fnd;
        r.elem   = elem;
        r.last   = last;
        replies_due.push_back(r);
    endfunction

    task automatic apply_request(req_t req, logic signed [31:0] key);
        int pos;
        bit hit;
        pos = lower_slot(key);
        hit = (pos < members.size()) && (members[pos] == key);
        case (req)
            REQ_INSERT: begin
                if (hit) begin
                    queue_reply(STS_DUPLICATE, 1'b0, '0, 1'b1);
                end else if (members.size() >= CAPACITY) begin
                    queue_reply(STS_FULL, 1'b0, '0, 1'b1);
                end else begin
                    members.insert(pos, key);
                    queue_reply(STS_INSERTED, 1'b0, '0, 1'b1);
                end
            end
            REQ_REMOVE: begin
                if (hit) begin
                    members.delete(pos);
                    queue_reply(STS_REMOVED, 1'b0, '0, 1'b1);
                end else begin
                    queue_reply(STS_ABSENT, 1'b0, '0, 1'b1);
                end
            end
            REQ_SEARCH: begin
                queue_reply(STS_SEARCH, hit, '0, 1'b1);
            end
            default: begin
                if (members.size() == 0) begin
                    queue_reply(STS_EMPTY, 1'b0, '0, 1'b1);
                end else begin
                    foreach (members[i])
                        queue_reply(STS_ELEMENT, 1'b0, members[i], i == members.size() - 1);
                end
            end
        endcase
    endtask

    task automatic report_fault(string msg);
        faults++;
        if (faults <= 10)
            $display("%0t: %s", $time, msg);
    endtask

    task automatic check_reply();
        set_reply_t want;
        set_reply_t got;
        got.status = status_t'(m_tuser);
        got.found  = m_tdata[0];
        got.elem   = m_tdata[32:1];
        got.last   = m_tlast;
        if (replies_due.size() == 0) begin
            report_fault($sformatf("unexpected reply word: status %0d found %0b elem %0d last %0b",
                                   got.status, got.found, $signed(got.elem), got.last));
        end else begin
            want = replies_due.pop_front();
            if (got.status !== want.status || got.found !== want.found ||
                got.elem !== want.elem || got.last !== want.last)
                report_fault({
                    $sformatf("reply mismatch: want status %0d found %0b elem %0d last %0b",
                              want.status, want.found, $signed(want.elem), want.last),
                    $sformatf(", got status %0d found %0b elem %0d last %0b",
                              got.status, got.found, $signed(got.elem), got.last)});
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            members.delete();
            replies_due.delete();
        end else begin
            if (m_tvalid && m_tready)
                check_reply();
            if (s_tvalid && s_tready)
                apply_request(req_t'(s_tuser), $signed(s_tdata));
        end
        fail_count      <= faults;
        pending_replies <= replies_due.size();
    end

endmodule

[sim/tb_sorted_set_table.sv]
`timescale 1ns / 100ps
// Testbench top for the sorted set table: clock, reset, request stimulus and verdict.
// Directed corner requests, then random grow, shrink, mixed and fill-to-capacity rounds.
// Depends on sst_pkg, sorted_set_table and sorted_set_monitor.
module tb_sorted_set_table;
    import sst_pkg::*;

    localparam int ITEM_TARGET  = 320;
    localparam int POOL_SIZE    = 40;
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int DRAIN_CYCLES = 80;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [31:0] key_value
    logic [1:0]  s_tuser;   // [1:0] req_type
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // [0] found, [32:1] element_value, [39:33] zero
    logic [2:0]  m_tuser;   // [2:0] status
    logic        m_tlast;

    int          fail_count;
    int          pending_replies;
    int          cycle_count = 0;
    int          words_sent  = 0;
    bit          tx_steady   = 1'b0;
    bit          rx_steady   = 1'b0;
    logic [31:0] key_pool[POOL_SIZE];

    sorted_set_table #(.CAPACITY(CAPACITY_DEF)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    sorted_set_monitor #(.CAPACITY(CAPACITY_DEF)) u_monitor (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .fail_count      (fail_count),
        .pending_replies (pending_replies)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("FAIL sorted_set_table");
            $finish;
        end
    end

    // hold m_tready low for a random stall before each reply word, none during steady stretches
    initial begin
        int stall;
        m_tready = 1'b0;
        while (aresetn !== 1'b1)
            @(negedge aclk);
        forever begin
            if ($urandom_range(0, 31) == 0)
                rx_steady = !rx_steady;
            stall = rx_steady ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid)
                @(posedge aclk);
            @(negedge aclk);
        end
    end

    task automatic send_word(req_t req, logic [31:0] key);
        int gap;
        if ($urandom_range(0, 31) == 0)
            tx_steady = !tx_steady;
        gap = tx_steady ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= key;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
        words_sent++;
    endtask

    function automatic logic [31:0] pick_key();
        if ($urandom_range(0, 9) < 2)
            return $urandom;
        return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    initial begin
        int          order[POOL_SIZE];
        int          round;
        int          mode;
        int          ins_pct;
        int          rem_pct;
        int          srch_pct;
        int          r;
        int          j;
        int          tmp;
        bit          dup;
        logic [31:0] cand;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = REQ_INSERT;

        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hffff_ffff;
        for (int i = 4; i < POOL_SIZE; i++) begin
            do begin
                cand = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 40) - 20;
                dup  = 1'b0;
                for (int k = 0; k < i; k++)
                    if (key_pool[k] == cand)
                        dup = 1'b1;
            end while (dup);
            key_pool[i] = cand;
        end

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_word(REQ_LIST,   $urandom);
        send_word(REQ_SEARCH, 32'h0000_0000);
        send_word(REQ_REMOVE, 32'h0000_0005);
        send_word(REQ_INSERT, 32'h0000_0000);
        send_word(REQ_INSERT, 32'h8000_0000);
        send_word(REQ_INSERT, 32'h7fff_ffff);
        send_word(REQ_INSERT, 32'hffff_ffff);
        send_word(REQ_INSERT, 32'h0000_0001);
        send_word(REQ_INSERT, 32'h7fff_ffff);
        send_word(REQ_INSERT, 32'h8000_0000);
        send_word(REQ_SEARCH, 32'h8000_0000);
        send_word(REQ_SEARCH, 32'h7fff_ffff);
        send_word(REQ_SEARCH, 32'h0000_0002);
        send_word(REQ_LIST,   32'hffff_ffff);
        send_word(REQ_REMOVE, 32'h8000_0000);
        send_word(REQ_REMOVE, 32'h7fff_ffff);
        send_word(REQ_REMOVE, 32'h0000_0007);
        send_word(REQ_REMOVE, 32'h0000_0000);
        send_word(REQ_LIST,   32'h0000_0000);
        send_word(REQ_INSERT, 32'haaaa_aaaa);
        send_word(REQ_INSERT, 32'h5555_5555);
        send_word(REQ_SEARCH, 32'h5555_5555);
        send_word(REQ_LIST,   32'h5555_5555);

        round = 0;
        while (words_sent < ITEM_TARGET) begin
            mode = (round == 0) ? 3 : $urandom_range(0, 3);
            if (mode == 3) begin
                // fill to capacity in shuffled order, then hit the full set
                for (int i = 0; i < POOL_SIZE; i++)
                    order[i] = i;
                for (int i = POOL_SIZE - 1; i > 0; i--) begin
                    j        = $urandom_range(0, i);
                    tmp      = order[i];
                    order[i] = order[j];
                    order[j] = tmp;
                end
                for (int i = 0; i < POOL_SIZE; i++)
                    send_word(REQ_INSERT, key_pool[order[i]]);
                repeat (4) send_word(REQ_INSERT, pick_key());
                send_word(REQ_SEARCH, pick_key());
                send_word(REQ_LIST, $urandom);
            end else begin
                case (mode)
                    0:       begin ins_pct = 70; rem_pct = 80; srch_pct = 92; end
                    1:       begin ins_pct = 15; rem_pct = 75; srch_pct = 90; end
                    default: begin ins_pct = 35; rem_pct = 65; srch_pct = 90; end
                endcase
                repeat (30) begin
                    r = $urandom_range(0, 99);
                    if (r < ins_pct)
                        send_word(REQ_INSERT, pick_key());
                    else if (r < rem_pct)
                        send_word(REQ_REMOVE, pick_key());
                    else if (r < srch_pct)
                        send_word(REQ_SEARCH, pick_key());
                    else
                        send_word(REQ_LIST, $urandom);
                end
            end
            round++;
        end
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (pending_replies != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && pending_replies == 0)
            $display("PASS sorted_set_table");
        else
            $display("FAIL sorted_set_table");
        $finish;
    end

endmodule

[files.f]
rtl/core/sst_pkg.sv
rtl/core/sst_cell.sv
rtl/core/sst_chain.sv
rtl/core/sorted_set_table.sv
sim/sorted_set_monitor.sv
sim/tb_sorted_set_table.sv
